[rtl/core/hfa_pkg.sv]
// Shared types and constants for the Hilbert FIR analytic signal unit.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package hfa_pkg;

	localparam int HalfLen  = 15;
	localparam int SampleW  = 16;
	localparam int HistLen  = 2 * HalfLen + 1;
	localparam int NumCoef  = 8;
	localparam int CoefW    = 18;
	localparam int FracW    = 17;
	localparam int DiffW    = SampleW + 1;
	localparam int ProdW    = CoefW + DiffW;
	localparam int AccW     = ProdW + 3;
	localparam int QW       = AccW - FracW;
	localparam int CntW     = 4;
	localparam int CfgIdxW  = 3;
	localparam int QDepth   = 4;
	localparam int QPtrW    = 2;
	localparam int QCntW    = 3;

	localparam logic signed [CoefW-1:0] Coef1Reset = 18'sd83443;
	localparam logic signed [QW-1:0] SatMax = QW'((2 ** (SampleW - 1)) - 1);
	localparam logic signed [QW-1:0] SatMin = -SatMax - QW'(1);

	// One queued sample with what the front decided about it
	typedef struct packed {
		logic [SampleW-1:0] sample;
		logic               block_end;
		logic               emit;
		logic [CntW-1:0]    cnt;
	} hfa_op_t;

	// Tap differences handed from the delay line to the MAC
	typedef struct packed {
		logic                              valid;
		logic                              last;
		logic [SampleW-1:0]                real_v;
		logic [NumCoef-1:0][DiffW-1:0]     diff;
	} hfa_tap_t;

endpackage

`default_nettype wire

[rtl/core/hilbert_fir_analytic_signal_unit.sv]
// Top level of the Hilbert FIR analytic signal unit.
// Depends on hfa_pkg, hfa_front, hfa_back, hfa_filt.
//
//   channel   signals                                          transfer when
//   input     in_valid/in_stall, sample, block_end             in_valid && !in_stall
//   output    out_valid/out_stall, real_part, imag_part,       out_valid && !out_stall
//             imag_clipped, final_output
//   config    cfg_we, cfg_index, cfg_data                      cfg_we
//
// One sample per clock is taken and one result per clock is given in steady flow while out_stall is low.
// A block_end sample holds the delay line for the sample itself plus 15 zero
// shifts, one per cycle while the pipeline advances; a 4-entry queue keeps taking
// input meanwhile. A head sample passes the s1, s2, s3, s4 and output registers.
// Reset (arst_n low) clears delay line, counters, queue and loads the default taps.
// out_stall freezes the back pipeline while out_valid is high; in_stall rises only on a full queue.
`default_nettype none

module hilbert_fir_analytic_signal_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [hfa_pkg::SampleW-1:0]  sample,
	input  wire logic                         block_end,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [hfa_pkg::SampleW-1:0]       real_part,
	output logic [hfa_pkg::SampleW-1:0]       imag_part,
	output logic                              imag_clipped,
	output logic                              final_output,
	input  wire logic                         cfg_we,
	input  wire logic [hfa_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [hfa_pkg::CoefW-1:0]    cfg_data
);

	hfa_pkg::hfa_op_t  head;
	hfa_pkg::hfa_tap_t tap;
	logic              head_valid;
	logic              pop;
	logic              adv;

	hfa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.block_end  (block_end),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	hfa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.tap        (tap)
	);

	hfa_filt u_filt (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tap          (tap),
		.adv          (adv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.real_part    (real_part),
		.imag_part    (imag_part),
		.imag_clipped (imag_clipped),
		.final_output (final_output)
	);

endmodule

`default_nettype wire

[rtl/core/hfa_front.sv]
// Input side: takes samples, tracks the block fill count, queues operations.
// Depends on hfa_pkg.
`default_nettype none

module hfa_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [hfa_pkg::SampleW-1:0] sample,
	input  wire logic                       block_end,
	input  wire logic                       pop,
	output hfa_pkg::hfa_op_t                head,
	output logic                            head_valid
);

	hfa_pkg::hfa_op_t                 q_mem_q [hfa_pkg::QDepth];
	logic [hfa_pkg::QPtrW-1:0]        wr_ptr_q;
	logic [hfa_pkg::QPtrW-1:0]        rd_ptr_q;
	logic [hfa_pkg::QCntW-1:0]        count_q;
	logic [hfa_pkg::CntW-1:0]         seen_q;
	logic                             push;
	hfa_pkg::hfa_op_t                 new_op;

	assign in_stall   = (count_q == hfa_pkg::QCntW'(hfa_pkg::QDepth));
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign head       = q_mem_q[rd_ptr_q];

	always_comb begin
		new_op.sample    = sample;
		new_op.block_end = block_end;
		new_op.emit      = (seen_q == hfa_pkg::CntW'(hfa_pkg::HalfLen));
		new_op.cnt       = seen_q;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			seen_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				if (block_end) begin
					seen_q <= '0;
				end else if (seen_q != hfa_pkg::CntW'(hfa_pkg::HalfLen)) begin
					seen_q <= seen_q + 1'b1;
				end
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/hfa_back.sv]
// Delay line and block flush sequencer; forms the tap differences (stage 1).
// Depends on hfa_pkg.
`default_nettype none

module hfa_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire hfa_pkg::hfa_op_t head,
	input  wire logic             head_valid,
	output logic                  pop,
	output hfa_pkg::hfa_tap_t     tap
);

	logic [hfa_pkg::SampleW-1:0] hist_q [hfa_pkg::HistLen];
	logic [hfa_pkg::SampleW-1:0] hist_n [hfa_pkg::HistLen];
	logic                        flush_q;
	logic [hfa_pkg::CntW-1:0]    j_q;
	logic [hfa_pkg::CntW-1:0]    fcnt_q;
	logic                        step;
	logic                        emit;
	logic                        last;
	logic [hfa_pkg::CntW:0]      fsum;

	logic                                        valid_s1;
	logic                                        last_s1;
	logic [hfa_pkg::SampleW-1:0]                 real_s1;
	logic [hfa_pkg::NumCoef-1:0][hfa_pkg::DiffW-1:0] diff_s1;
	logic [hfa_pkg::NumCoef-1:0][hfa_pkg::DiffW-1:0] diff_n;

	assign step = adv && (flush_q || head_valid);
	assign pop  = adv && !flush_q && head_valid;
	assign fsum = {1'b0, fcnt_q} + {1'b0, j_q};
	assign last = flush_q && (j_q == hfa_pkg::CntW'(hfa_pkg::HalfLen));

	always_comb begin
		if (flush_q) begin
			emit = (fsum >= (hfa_pkg::CntW + 1)'(hfa_pkg::HalfLen));
		end else begin
			emit = head.emit;
		end
	end

	always_comb begin
		hist_n[0] = flush_q ? '0 : head.sample;
		for (int k = 1; k < hfa_pkg::HistLen; k++) begin
			hist_n[k] = hist_q[k-1];
		end
	end

	// older sample minus newer sample at each odd offset around the centre
	always_comb begin
		for (int m = 0; m < hfa_pkg::NumCoef; m++) begin
			if (2 * m + 1 <= hfa_pkg::HalfLen) begin
				diff_n[m] = {hist_n[hfa_pkg::HalfLen + 2*m + 1][hfa_pkg::SampleW-1],
				             hist_n[hfa_pkg::HalfLen + 2*m + 1]}
				          - {hist_n[hfa_pkg::HalfLen - 2*m - 1][hfa_pkg::SampleW-1],
				             hist_n[hfa_pkg::HalfLen - 2*m - 1]};
			end else begin
				diff_n[m] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < hfa_pkg::HistLen; k++) begin
				hist_q[k] <= '0;
			end
			flush_q <= 1'b0;
			j_q     <= '0;
			fcnt_q  <= '0;
		end else begin
			if (step) begin
				for (int k = 0; k < hfa_pkg::HistLen; k++) begin
					hist_q[k] <= last ? '0 : hist_n[k];
				end
			end
			if (pop && head.block_end) begin
				flush_q <= 1'b1;
				j_q     <= hfa_pkg::CntW'(1);
				fcnt_q  <= head.cnt;
			end else if (step && flush_q) begin
				if (last) begin
					flush_q <= 1'b0;
					j_q     <= '0;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= last;
			real_s1 <= hist_n[hfa_pkg::HalfLen];
			diff_s1 <= diff_n;
		end
	end

	assign tap.valid  = valid_s1;
	assign tap.last   = last_s1;
	assign tap.real_v = real_s1;
	assign tap.diff   = diff_s1;

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last) |=> (!flush_q && hist_q[hfa_pkg::HalfLen] == '0
		                    && hist_q[hfa_pkg::HistLen-1] == '0))
		else $error("delay line not cleared after block flush");

	a_flush_start: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.block_end) |=> (flush_q && j_q == hfa_pkg::CntW'(1)))
		else $error("flush did not start after block end");

	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (j_q != '0))
		else $error("flush step counter out of range");

	a_last_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && step && last) |=> (valid_s1 && last_s1))
		else $error("final flush step did not produce a result");

endmodule

`default_nettype wire

[rtl/core/hfa_filt.sv]
// Coefficient registers, multiply and adder tree, rounding, output register.
// Depends on hfa_pkg.
`default_nettype none

module hfa_filt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [hfa_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [hfa_pkg::CoefW-1:0]    cfg_data,
	input  wire hfa_pkg::hfa_tap_t            tap,
	output logic                              adv,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [hfa_pkg::SampleW-1:0]       real_part,
	output logic [hfa_pkg::SampleW-1:0]       imag_part,
	output logic                              imag_clipped,
	output logic                              final_output
);

	logic signed [hfa_pkg::CoefW-1:0]   coef_q [hfa_pkg::NumCoef];

	logic signed [hfa_pkg::ProdW-1:0]   prod_s2 [hfa_pkg::NumCoef];
	logic signed [hfa_pkg::ProdW:0]     sum_s3  [hfa_pkg::NumCoef/2];
	logic signed [hfa_pkg::ProdW+1:0]   sum_s4  [hfa_pkg::NumCoef/4];
	logic                               valid_s2, valid_s3, valid_s4;
	logic                               last_s2, last_s3, last_s4;
	logic [hfa_pkg::SampleW-1:0]        real_s2, real_s3, real_s4;

	logic signed [hfa_pkg::AccW-1:0]    acc;
	logic signed [hfa_pkg::AccW-1:0]    biased;
	logic signed [hfa_pkg::QW-1:0]      q;
	logic [hfa_pkg::SampleW-1:0]        imag_n;
	logic                               clip_n;

	logic                               out_valid_q;
	logic                               out_last_q;
	logic                               out_clip_q;
	logic [hfa_pkg::SampleW-1:0]        out_real_q;
	logic [hfa_pkg::SampleW-1:0]        out_imag_q;

	assign adv = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < hfa_pkg::NumCoef; m++) begin
				coef_q[m] <= (m == 0) ? hfa_pkg::Coef1Reset : '0;
			end
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s2    <= tap.valid;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int m = 0; m < hfa_pkg::NumCoef; m++) begin
				prod_s2[m] <= coef_q[m] * $signed(tap.diff[m]);
			end
			last_s2 <= tap.last;
			real_s2 <= tap.real_v;

			for (int k = 0; k < hfa_pkg::NumCoef/2; k++) begin
				sum_s3[k] <= (hfa_pkg::ProdW+1)'(prod_s2[2*k])
				           + (hfa_pkg::ProdW+1)'(prod_s2[2*k+1]);
			end
			last_s3 <= last_s2;
			real_s3 <= real_s2;

			for (int k = 0; k < hfa_pkg::NumCoef/4; k++) begin
				sum_s4[k] <= (hfa_pkg::ProdW+2)'(sum_s3[2*k])
				           + (hfa_pkg::ProdW+2)'(sum_s3[2*k+1]);
			end
			last_s4 <= last_s3;
			real_s4 <= real_s3;

			out_last_q <= last_s4;
			out_real_q <= real_s4;
			out_imag_q <= imag_n;
			out_clip_q <= clip_n;
		end
	end

	// round half up at the Q1.17 point, then clamp to the sample range
	always_comb begin
		acc    = hfa_pkg::AccW'(sum_s4[0]) + hfa_pkg::AccW'(sum_s4[1]);
		biased = acc + (hfa_pkg::AccW'(1) <<< (hfa_pkg::FracW - 1));
		q      = biased[hfa_pkg::AccW-1:hfa_pkg::FracW];
		priority if (q > hfa_pkg::SatMax) begin
			imag_n = hfa_pkg::SatMax[hfa_pkg::SampleW-1:0];
			clip_n = 1'b1;
		end else if (q < hfa_pkg::SatMin) begin
			imag_n = hfa_pkg::SatMin[hfa_pkg::SampleW-1:0];
			clip_n = 1'b1;
		end else begin
			imag_n = q[hfa_pkg::SampleW-1:0];
			clip_n = 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign real_part    = out_real_q;
	assign imag_part    = out_imag_q;
	assign imag_clipped = out_clip_q;
	assign final_output = out_last_q;

endmodule

`default_nettype wire
